FILE: rtl/core/owsr_pkg.sv
`timescale 1ns / 1ps

package owsr_pkg;

    // number of rom bytes sent after the read rom command
    localparam int unsigned ROM_BYTES = 8;

    // command code and counter ceiling
    localparam logic [7:0] CMD_READ_ROM = 8'h33;
    localparam logic [9:0] COUNT_MAX    = 10'd1023;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] CFG_ROM_CODE        = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_TICKS     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_WAIT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRESENCE_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SAMPLE_DELAY    = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_HOLD       = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_ONE_HOLD        = 3'd6;
    localparam int unsigned CFG_DATA_W = 64;

    // register values after reset
    localparam logic [63:0] RST_ROM_CODE        = 64'hDD00_0014_7BCF_F101;
    localparam logic [9:0]  RST_RESET_TICKS     = 10'd350;
    localparam logic [7:0]  RST_PRESENCE_WAIT   = 8'd15;
    localparam logic [7:0]  RST_PRESENCE_LENGTH = 8'd60;
    localparam logic [7:0]  RST_SAMPLE_DELAY    = 8'd40;
    localparam logic [7:0]  RST_ZERO_HOLD       = 8'd40;
    localparam logic [7:0]  RST_ONE_HOLD        = 8'd2;

    // protocol phases
    typedef enum logic [7:0] {
        PH_IDLE       = 8'b0000_0001,
        PH_RESET_LOW  = 8'b0000_0010,
        PH_PWAIT      = 8'b0000_0100,
        PH_PRESENCE   = 8'b0000_1000,
        PH_CMD_EDGE   = 8'b0001_0000,
        PH_CMD_SAMPLE = 8'b0010_0000,
        PH_SEND_EDGE  = 8'b0100_0000,
        PH_SEND_HOLD  = 8'b1000_0000
    } t_phase;

    typedef struct packed {
        logic [63:0] rom_code;
        logic [9:0]  reset_ticks;
        logic [7:0]  presence_wait;
        logic [7:0]  presence_length;
        logic [7:0]  sample_delay;
        logic [7:0]  zero_hold;
        logic [7:0]  one_hold;
    } t_cfg;

    typedef struct packed {
        t_phase      phase;
        logic [9:0]  tick_count;
        logic [2:0]  bit_index;
        logic [2:0]  byte_index;
        logic [7:0]  send_shift;
        logic [7:0]  command_shift;
        logic        last_level;
    } t_state;

    typedef struct packed {
        logic drive_low;
        logic rom_done;
    } t_result;

endpackage

FILE: rtl/core/owsr_in_if.sv
`timescale 1ns / 1ps

interface owsr_in_if;
    logic valid;
    logic ready;
    logic line_level;

    modport source (output valid, output line_level, input ready);
    modport sink   (input valid, input line_level, output ready);
endinterface

FILE: rtl/core/owsr_out_if.sv
`timescale 1ns / 1ps

interface owsr_out_if;
    logic valid;
    logic ready;
    logic drive_low;
    logic rom_done;

    modport source (output valid, output drive_low, output rom_done, input ready);
    modport sink   (input valid, input drive_low, input rom_done, output ready);
endinterface

FILE: rtl/core/owsr_step.sv
`timescale 1ns / 1ps

module owsr_step (
    input  owsr_pkg::t_state  i_state,
    input  owsr_pkg::t_cfg    i_cfg,
    input  logic              i_line_level,
    output owsr_pkg::t_state  o_state,
    output owsr_pkg::t_result o_result
);
    import owsr_pkg::*;

    // saturating tick counter increment
    function automatic logic [9:0] sat_inc(input logic [9:0] v);
        return (v == COUNT_MAX) ? v : v + 10'd1;
    endfunction

    // pick one rom byte
    function automatic logic [7:0] rom_byte(input logic [63:0] rom, input logic [2:0] idx);
        return rom[{idx, 3'b000} +: 8];
    endfunction

    logic       w_fall;
    logic [9:0] w_inc;

    assign w_fall = i_state.last_level && !i_line_level;
    assign w_inc  = sat_inc(i_state.tick_count);

    // next state and result for one tick
    always_comb begin
        t_state     s;
        logic [9:0] v_tc;
        logic [9:0] v_hold;
        logic [7:0] v_cmd;
        logic [3:0] v_next_byte;

        s           = i_state;
        v_tc        = i_state.tick_count;
        v_hold      = '0;
        v_cmd       = '0;
        v_next_byte = '0;
        o_result    = '0;

        unique case (i_state.phase)
            PH_RESET_LOW: begin
                if (!i_line_level) begin
                    s.tick_count = w_inc;
                end else if (i_state.tick_count >= i_cfg.reset_ticks) begin
                    s.phase         = PH_PWAIT;
                    s.tick_count    = '0;
                    s.bit_index     = '0;
                    s.byte_index    = '0;
                    s.command_shift = '0;
                end else begin
                    s.phase      = PH_IDLE;
                    s.tick_count = '0;
                    s.bit_index  = '0;
                    s.byte_index = '0;
                end
            end
            PH_PWAIT: begin
                s.tick_count = w_inc;
                if (w_inc >= {2'b00, i_cfg.presence_wait}) begin
                    // presence pulse begins on this tick, unless its length is zero
                    if (i_cfg.presence_length != 8'd0) begin
                        s.phase            = PH_PRESENCE;
                        s.tick_count       = 10'd1;
                        o_result.drive_low = 1'b1;
                    end else begin
                        s.phase      = PH_CMD_EDGE;
                        s.tick_count = '0;
                    end
                end
            end
            PH_PRESENCE: begin
                if (i_state.tick_count < {2'b00, i_cfg.presence_length}) begin
                    o_result.drive_low = 1'b1;
                    s.tick_count       = w_inc;
                end else begin
                    s.phase      = PH_CMD_EDGE;
                    s.tick_count = '0;
                end
            end
            PH_CMD_EDGE: begin
                if (w_fall) begin
                    s.phase      = PH_CMD_SAMPLE;
                    s.tick_count = '0;
                end
            end
            PH_CMD_SAMPLE: begin
                s.tick_count = w_inc;
                if (w_inc >= {2'b00, i_cfg.sample_delay}) begin
                    v_cmd           = {i_line_level, i_state.command_shift[7:1]};
                    s.command_shift = v_cmd;
                    s.tick_count    = '0;
                    if (i_state.bit_index != 3'd7) begin
                        s.bit_index = i_state.bit_index + 3'd1;
                        s.phase     = PH_CMD_EDGE;
                    end else if (v_cmd == CMD_READ_ROM) begin
                        s.bit_index  = '0;
                        s.byte_index = '0;
                        s.send_shift = rom_byte(i_cfg.rom_code, 3'd0);
                        s.phase      = PH_SEND_EDGE;
                    end else begin
                        s.phase      = PH_IDLE;
                        s.bit_index  = '0;
                        s.byte_index = '0;
                    end
                end
            end
            PH_SEND_EDGE, PH_SEND_HOLD: begin
                // the hold starts on the falling edge tick itself
                if (i_state.phase == PH_SEND_HOLD || w_fall) begin
                    if (i_state.phase == PH_SEND_EDGE) begin
                        v_tc = '0;
                    end
                    s.phase = PH_SEND_HOLD;
                    v_hold  = {2'b00, i_state.send_shift[0] ? i_cfg.one_hold : i_cfg.zero_hold};
                    if (v_tc < v_hold) begin
                        o_result.drive_low = 1'b1;
                        s.tick_count       = sat_inc(v_tc);
                    end else begin
                        // bit finished
                        s.send_shift = {1'b0, i_state.send_shift[7:1]};
                        s.tick_count = '0;
                        s.phase      = PH_SEND_EDGE;
                        v_next_byte  = {1'b0, i_state.byte_index} + 4'd1;
                        if (i_state.bit_index != 3'd7) begin
                            s.bit_index = i_state.bit_index + 3'd1;
                        end else begin
                            s.bit_index = '0;
                            if (v_next_byte >= 4'(ROM_BYTES)) begin
                                s.phase           = PH_IDLE;
                                s.byte_index      = '0;
                                o_result.rom_done = 1'b1;
                            end else begin
                                s.byte_index = v_next_byte[2:0];
                                s.send_shift = rom_byte(i_cfg.rom_code, v_next_byte[2:0]);
                            end
                        end
                    end
                end
            end
            default: begin
                // idle, and any code that is not a phase
                if (w_fall) begin
                    s.phase      = PH_RESET_LOW;
                    s.tick_count = 10'd1;
                end
            end
        endcase

        s.last_level = i_line_level;
        o_state      = s;
    end

endmodule

FILE: rtl/core/onewire_slave_read_rom_responder.sv
`timescale 1ns / 1ps

// 1-Wire slave that answers Read ROM, fed one request per microsecond tick carrying the
// sampled bus level, and giving one result per tick (drive_low, rom_done). A low of at
// least reset_ticks followed by a rise is a bus reset; after presence_wait ticks the slave
// drives presence for presence_length ticks, samples eight command bits LSB first at
// sample_delay after each falling edge, and on 0x33 sends the eight rom_code bytes, byte
// zero first, holding the line low one_hold ticks for a 1 and zero_hold ticks for a 0.
// The whole state update is one pass of logic between the state register and the result
// register, so a request is taken every cycle while the result register is empty or being
// read. The user must write configuration through the plain write port only while the
// block is idle (the block itself does not enforce it); it takes effect on the next tick.
module onewire_slave_read_rom_responder (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [owsr_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [owsr_pkg::CFG_DATA_W-1:0]        i_cfg_data,
    owsr_in_if.sink                                i_in,
    owsr_out_if.source                             o_out
);
    import owsr_pkg::*;

    t_cfg    r_cfg;
    t_state  r_state;
    t_state  n_state;
    t_result w_res;
    logic    r_out_valid;
    logic    r_drive_low;
    logic    r_rom_done;
    logic    w_in_acc;

    // request handshake
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign w_in_acc   = i_in.valid && i_in.ready;

    // per tick logic
    owsr_step u_step (
        .i_state      (r_state),
        .i_cfg        (r_cfg),
        .i_line_level (i_in.line_level),
        .o_state      (n_state),
        .o_result     (w_res)
    );

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.rom_code        <= RST_ROM_CODE;
            r_cfg.reset_ticks     <= RST_RESET_TICKS;
            r_cfg.presence_wait   <= RST_PRESENCE_WAIT;
            r_cfg.presence_length <= RST_PRESENCE_LENGTH;
            r_cfg.sample_delay    <= RST_SAMPLE_DELAY;
            r_cfg.zero_hold       <= RST_ZERO_HOLD;
            r_cfg.one_hold        <= RST_ONE_HOLD;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ROM_CODE:        r_cfg.rom_code        <= i_cfg_data;
                CFG_RESET_TICKS:     r_cfg.reset_ticks     <= i_cfg_data[9:0];
                CFG_PRESENCE_WAIT:   r_cfg.presence_wait   <= i_cfg_data[7:0];
                CFG_PRESENCE_LENGTH: r_cfg.presence_length <= i_cfg_data[7:0];
                CFG_SAMPLE_DELAY:    r_cfg.sample_delay    <= i_cfg_data[7:0];
                CFG_ZERO_HOLD:       r_cfg.zero_hold       <= i_cfg_data[7:0];
                CFG_ONE_HOLD:        r_cfg.one_hold        <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

    // protocol state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.phase         <= PH_IDLE;
            r_state.tick_count    <= '0;
            r_state.bit_index     <= '0;
            r_state.byte_index    <= '0;
            r_state.send_shift    <= '0;
            r_state.command_shift <= '0;
            r_state.last_level    <= 1'b1;
        end else if (w_in_acc) begin
            r_state <= n_state;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_in_acc) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_drive_low <= w_res.drive_low;
            r_rom_done  <= w_res.rom_done;
        end
    end

    assign o_out.valid     = r_out_valid;
    assign o_out.drive_low = r_drive_low;
    assign o_out.rom_done  = r_rom_done;

    // finishing the rom always returns to idle
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_res.rom_done |=> r_state.phase == PH_IDLE)
        else $error("rom done without return to idle");

    // the line is pulled only while presence or a send hold is running
    a_drive_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && w_res.drive_low |=>
            r_state.phase == PH_PRESENCE || r_state.phase == PH_SEND_HOLD)
        else $error("drive low outside presence or send hold");

    // edge wait phases keep a cleared tick counter
    a_edge_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state.phase == PH_CMD_EDGE || r_state.phase == PH_SEND_EDGE
            |-> r_state.tick_count == 10'd0)
        else $error("tick counter running while waiting for an edge");

    // a result is registered on every accepted request
    a_result_loaded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> r_out_valid && r_drive_low == $past(w_res.drive_low))
        else $error("result register not loaded");

endmodule

FILE: tb/sv/onewire_slave_read_rom_responder_tb.sv
`timescale 1ns / 1ps

module onewire_slave_read_rom_responder_tb;
    import owsr_pkg::*;

    localparam int IDLE_LIMIT = 2000;

    typedef enum int {
        SINK_OPEN,
        SINK_RANDOM,
        SINK_SPARSE,
        SINK_PERIODIC
    } t_sink_mode;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    owsr_in_if  bus_in ();
    owsr_out_if bus_out ();

    onewire_slave_read_rom_responder i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_in        (bus_in),
        .o_out       (bus_out)
    );

    // slave copy kept by the testbench
    t_cfg       slave_cfg;
    t_phase     slave_phase;
    logic [9:0] slave_ticks;
    logic [2:0] slave_bit;
    logic [2:0] slave_byte;
    logic [7:0] slave_send_sr;
    logic [7:0] slave_cmd_sr;
    logic       slave_last;

    t_result expected_ticks[$];
    int      n_errors;
    int      n_sent;
    int      burst_left;
    int      idle_cycles;

    // clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic void go_idle();
        slave_phase = PH_IDLE;
        slave_ticks = '0;
        slave_bit   = '0;
        slave_byte  = '0;
    endfunction

    function automatic void count_tick();
        if (slave_ticks < COUNT_MAX) slave_ticks++;
    endfunction

    // one microsecond tick of the slave: returns what it drives this tick
    function automatic t_result slave_tick(input logic lvl);
        t_result    res;
        logic       fall;
        logic [7:0] hold;
        res  = '0;
        fall = slave_last && !lvl;
        case (slave_phase)
            PH_RESET_LOW: begin
                if (!lvl) begin
                    count_tick();
                end else if (slave_ticks >= slave_cfg.reset_ticks) begin
                    slave_phase  = PH_PWAIT;
                    slave_ticks  = '0;
                    slave_bit    = '0;
                    slave_byte   = '0;
                    slave_cmd_sr = '0;
                end else begin
                    go_idle();
                end
            end
            PH_PWAIT: begin
                count_tick();
                if (slave_ticks >= slave_cfg.presence_wait) begin
                    slave_phase = PH_PRESENCE;
                    slave_ticks = '0;
                end
            end
            PH_CMD_EDGE: begin
                if (fall) begin
                    slave_phase = PH_CMD_SAMPLE;
                    slave_ticks = '0;
                end
            end
            PH_CMD_SAMPLE: begin
                count_tick();
                if (slave_ticks >= slave_cfg.sample_delay) begin
                    slave_cmd_sr = {lvl, slave_cmd_sr[7:1]};
                    slave_ticks  = '0;
                    if (slave_bit < 3'd7) begin
                        slave_bit++;
                        slave_phase = PH_CMD_EDGE;
                    end else if (slave_cmd_sr == CMD_READ_ROM) begin
                        slave_bit     = '0;
                        slave_byte    = '0;
                        slave_send_sr = slave_cfg.rom_code[7:0];
                        slave_phase   = PH_SEND_EDGE;
                    end else begin
                        go_idle();
                    end
                end
            end
            PH_SEND_EDGE: begin
                if (fall) begin
                    slave_phase = PH_SEND_HOLD;
                    slave_ticks = '0;
                end
            end
            PH_PRESENCE, PH_SEND_HOLD: begin
            end
            default: begin
                if (fall) begin
                    slave_phase = PH_RESET_LOW;
                    slave_ticks = 10'd1;
                end
            end
        endcase

        // presence pulse, which may start on the tick the wait ends
        if (slave_phase == PH_PRESENCE) begin
            if (slave_ticks < slave_cfg.presence_length) begin
                res.drive_low = 1'b1;
                count_tick();
            end else begin
                slave_phase = PH_CMD_EDGE;
                slave_ticks = '0;
            end
        end

        // rom bit hold, which starts on the falling-edge tick
        if (slave_phase == PH_SEND_HOLD) begin
            hold = slave_send_sr[0] ? slave_cfg.one_hold : slave_cfg.zero_hold;
            if (slave_ticks < hold) begin
                res.drive_low = 1'b1;
                count_tick();
            end else begin
                slave_send_sr = slave_send_sr >> 1;
                slave_ticks   = '0;
                slave_phase   = PH_SEND_EDGE;
                if (slave_bit < 3'd7) begin
                    slave_bit++;
                end else begin
                    slave_bit = '0;
                    if (int'(slave_byte) + 1 >= ROM_BYTES) begin
                        res.rom_done = 1'b1;
                        go_idle();
                    end else begin
                        slave_byte++;
                        slave_send_sr = slave_cfg.rom_code[8*slave_byte +: 8];
                    end
                end
            end
        end

        slave_last = lvl;
        return res;
    endfunction

    // one request carrying a bus sample, sent in bursts with random gaps
    task automatic send_tick(input logic lvl);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 24);
            if (gap > 0) begin
                bus_in.valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        bus_in.valid      <= 1'b1;
        bus_in.line_level <= lvl;
        @(posedge i_clk);
        while (bus_in.ready !== 1'b1) @(posedge i_clk);
        expected_ticks.push_back(slave_tick(lvl));
        n_sent++;
    endtask

    task automatic send_run(input logic lvl, input int n);
        repeat (n) send_tick(lvl);
    endtask

    // stop sending and let every pending result drain
    task automatic settle();
        bus_in.valid <= 1'b0;
        while (expected_ticks.size() != 0) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        case (idx)
            CFG_ROM_CODE:        slave_cfg.rom_code        = val;
            CFG_RESET_TICKS:     slave_cfg.reset_ticks     = val[9:0];
            CFG_PRESENCE_WAIT:   slave_cfg.presence_wait   = val[7:0];
            CFG_PRESENCE_LENGTH: slave_cfg.presence_length = val[7:0];
            CFG_SAMPLE_DELAY:    slave_cfg.sample_delay    = val[7:0];
            CFG_ZERO_HOLD:       slave_cfg.zero_hold       = val[7:0];
            CFG_ONE_HOLD:        slave_cfg.one_hold        = val[7:0];
            default: begin
            end
        endcase
    endtask

    task automatic set_timing(input int rt, input int pw, input int pl,
                              input int sd, input int zh, input int oh);
        settle();
        write_reg(CFG_RESET_TICKS, 64'(rt));
        write_reg(CFG_PRESENCE_WAIT, 64'(pw));
        write_reg(CFG_PRESENCE_LENGTH, 64'(pl));
        write_reg(CFG_SAMPLE_DELAY, 64'(sd));
        write_reg(CFG_ZERO_HOLD, 64'(zh));
        write_reg(CFG_ONE_HOLD, 64'(oh));
    endtask

    task automatic set_rom(input logic [63:0] code);
        settle();
        write_reg(CFG_ROM_CODE, code);
    endtask

    // master reset low, then high long enough to cover the presence pulse
    task automatic bus_reset(input int low_n);
        send_tick(1'b1);
        send_run(1'b0, low_n);
        send_run(1'b1, int'(slave_cfg.presence_wait) + int'(slave_cfg.presence_length)
                       + 2 + $urandom_range(0, 2));
    endtask

    // master write slots: a 1 is released before the sample tick, a 0 held past it
    task automatic command_byte(input logic [7:0] cmd);
        int st, low_n, high_n;
        st = (slave_cfg.sample_delay == 0) ? 1 : int'(slave_cfg.sample_delay);
        for (int b = 0; b < 8; b++) begin
            if (cmd[b]) begin
                low_n = $urandom_range(1, st);
            end else begin
                low_n = st + 1 + $urandom_range(0, 1);
            end
            high_n = ((st + 1 - low_n > 1) ? st + 1 - low_n : 1) + $urandom_range(0, 1);
            send_run(1'b0, low_n);
            send_run(1'b1, high_n);
        end
    endtask

    // master read slot, now and then cut short so the next edge lands in the hold
    task automatic read_slot(input int low_n);
        int hold, high_n;
        hold   = slave_send_sr[0] ? int'(slave_cfg.one_hold) : int'(slave_cfg.zero_hold);
        high_n = ((hold + 1 - low_n > 1) ? hold + 1 - low_n : 1) + $urandom_range(0, 1);
        if ($urandom_range(0, 15) == 0) high_n = 1;
        send_run(1'b0, low_n);
        send_run(1'b1, high_n);
    endtask

    // plain slots until the slave is back in idle
    task automatic recover();
        int lw;
        lw = int'(slave_cfg.presence_wait) + int'(slave_cfg.presence_length) + 1;
        if (int'(slave_cfg.sample_delay) > lw) lw = int'(slave_cfg.sample_delay);
        if (int'(slave_cfg.zero_hold) > lw) lw = int'(slave_cfg.zero_hold);
        if (int'(slave_cfg.one_hold) > lw) lw = int'(slave_cfg.one_hold);
        while (slave_phase != PH_IDLE) begin
            send_tick(1'b0);
            send_run(1'b1, lw + 2);
        end
    endtask

    // reset, presence, command and, on read rom, all rom slots
    task automatic transaction(input logic [7:0] cmd);
        recover();
        bus_reset(int'(slave_cfg.reset_ticks) + $urandom_range(0, 3));
        command_byte(cmd);
        if (cmd == CMD_READ_ROM) repeat (ROM_BYTES * 8) read_slot($urandom_range(1, 2));
    endtask

    task automatic test_reset_values();
        // rom code as left by reset, sample on the tick after the edge, no low for a one
        set_timing(2, 1, 2, 0, 2, 0);
        transaction(CMD_READ_ROM);
    endtask

    task automatic test_reset_length();
        // one tick short of the reset time, then exactly on it
        set_timing(6, 1, 2, 1, 2, 1);
        recover();
        bus_reset(5);
        bus_reset(6);
        command_byte(8'h0F);
        // shortest reset
        set_timing(1, 0, 1, 1, 1, 1);
        transaction(8'hF0);
    endtask

    task automatic test_presence();
        // no presence pulse at all
        set_timing(4, 0, 0, 2, 3, 1);
        transaction(8'h55);
        // presence after a wait
        set_timing(4, 3, 2, 2, 3, 1);
        transaction(8'hAA);
    endtask

    task automatic test_command();
        // near miss of the read rom code
        set_timing(3, 1, 1, 0, 2, 1);
        transaction(8'h32);
        // longer sample delay, command not read rom
        set_timing(3, 1, 1, 6, 2, 1);
        transaction(8'hB3);
    endtask

    task automatic test_rom_transfer();
        // long low inside the transfer is a slot, and holds change mid-transfer
        set_rom(64'hA5C3_0F96_3C5A_E117);
        set_timing(4, 2, 3, 2, 3, 1);
        recover();
        bus_reset(4);
        command_byte(CMD_READ_ROM);
        read_slot(12);
        repeat (20) read_slot(1);
        // no low driven for a zero
        set_timing(4, 2, 3, 2, 0, 3);
        repeat (43) read_slot(1);
    endtask

    task automatic test_random_traffic();
        int stop_at, pick, rt;
        repeat (2) begin
            set_rom({$urandom, $urandom});
            set_timing($urandom_range(1, 6), $urandom_range(0, 3), $urandom_range(0, 3),
                       $urandom_range(0, 3), $urandom_range(0, 3), $urandom_range(0, 3));
            rt      = int'(slave_cfg.reset_ticks);
            stop_at = n_sent + 25;
            while (n_sent < stop_at) begin
                pick = $urandom_range(0, 19);
                if (pick < 12) begin
                    transaction((pick < 2) ? CMD_READ_ROM : 8'($urandom));
                end else if (pick < 14) begin
                    // reset that is too short
                    recover();
                    if (rt > 1) begin
                        send_tick(1'b1);
                        send_run(1'b0, $urandom_range(1, rt - 1));
                        send_run(1'b1, 3);
                    end
                end else if (pick < 17) begin
                    repeat ($urandom_range(4, 40)) send_tick(1'($urandom));
                end else begin
                    // reset followed by ragged slots
                    recover();
                    bus_reset(rt);
                    repeat ($urandom_range(1, 6)) begin
                        send_tick(1'b0);
                        send_run(1'b1, $urandom_range(0, 3));
                    end
                end
            end
        end
    endtask

    // result receiver stalls on its own pattern
    initial begin : result_sink
        t_sink_mode mode;
        int         span;
        int         beat;
        bus_out.ready <= 1'b0;
        beat = 0;
        forever begin
            mode = t_sink_mode'($urandom_range(0, 3));
            span = $urandom_range(20, 150);
            repeat (span) begin
                @(posedge i_clk);
                beat++;
                case (mode)
                    SINK_OPEN:     bus_out.ready <= 1'b1;
                    SINK_RANDOM:   bus_out.ready <= ($urandom_range(0, 3) != 0);
                    SINK_SPARSE:   bus_out.ready <= ($urandom_range(0, 2) == 0);
                    default:       bus_out.ready <= ((beat % 4) != 3);
                endcase
            end
        end
    end

    // compare each accepted result with the oldest expected tick
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (bus_out.valid === 1'b1 && bus_out.ready === 1'b1) begin
            if (expected_ticks.size() == 0) begin
                n_errors++;
                $error("result with no request pending: drive_low %0b, rom_done %0b",
                       bus_out.drive_low, bus_out.rom_done);
            end else begin
                want = expected_ticks.pop_front();
                if (bus_out.drive_low !== want.drive_low) begin
                    n_errors++;
                    $error("drive_low: expected %0b, got %0b", want.drive_low,
                           bus_out.drive_low);
                end
                if (bus_out.rom_done !== want.rom_done) begin
                    n_errors++;
                    $error("rom_done: expected %0b, got %0b", want.rom_done,
                           bus_out.rom_done);
                end
            end
        end
    end

    // stop the run when nothing moves for too long
    initial begin : watchdog
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((bus_in.valid === 1'b1 && bus_in.ready === 1'b1) ||
                (bus_out.valid === 1'b1 && bus_out.ready === 1'b1)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("onewire_slave_read_rom_responder_tb: errors");
        $finish;
    end

    // main sequence
    initial begin : main_seq
        slave_cfg = '{rom_code:        RST_ROM_CODE,
                      reset_ticks:     RST_RESET_TICKS,
                      presence_wait:   RST_PRESENCE_WAIT,
                      presence_length: RST_PRESENCE_LENGTH,
                      sample_delay:    RST_SAMPLE_DELAY,
                      zero_hold:       RST_ZERO_HOLD,
                      one_hold:        RST_ONE_HOLD};
        go_idle();
        slave_send_sr = '0;
        slave_cmd_sr  = '0;
        slave_last    = 1'b1;
        n_errors      = 0;
        n_sent        = 0;
        burst_left    = 0;

        i_rst_n           <= 1'b0;
        i_cfg_we          <= 1'b0;
        i_cfg_index       <= CFG_ROM_CODE;
        i_cfg_data        <= '0;
        bus_in.valid      <= 1'b0;
        bus_in.line_level <= 1'b1;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_values();
        test_reset_length();
        test_presence();
        test_command();
        test_rom_transfer();
        test_random_traffic();

        settle();
        if (n_errors == 0 && expected_ticks.size() == 0) begin
            $display("onewire_slave_read_rom_responder_tb: clean");
        end else begin
            $display("onewire_slave_read_rom_responder_tb: errors");
        end
        $finish;
    end

endmodule
